>>> hw/rtl/ookwx_pkg.sv
// ----------------------------------------------------------------------------
// ookwx_pkg: shared types and constants for the ook weather sensor decoder
// frame phases, register indexes, reset values and crc-4 syndrome columns
// ----------------------------------------------------------------------------
package ookwx_pkg;

	localparam int FRAME_BITS = 40;

	localparam int SHORT_W = 12;
	localparam int LONG_W  = 13;
	localparam int TOL_W   = 11;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam int PAIRS_W = 3;
	localparam int TOTAL_W = 6;

	localparam logic [SHORT_W-1:0] SHORT_UNIT_RST = 12'd500;
	localparam logic [LONG_W-1:0]  LONG_UNIT_RST  = 13'd2000;
	localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 11'd150;

	localparam logic [PAIRS_W-1:0] PAIRS_MAX    = 3'd7;
	localparam logic [PAIRS_W-1:0] PAIRS_NEEDED = 3'd3;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 6'd63;
	localparam logic [TOTAL_W-1:0] TOTAL_FRAME  = 6'd40;

	localparam logic [7:0] CRC_POLY = 8'h30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_UNIT = 2'd0,
		REG_LONG_UNIT  = 2'd1,
		REG_TOLERANCE  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_PREAMBLE  = 2'd1,
		PH_WAIT_HIGH = 2'd2,
		PH_WAIT_GAP  = 2'd3
	} phase_t;

	typedef logic [3:0] crc_col_t [FRAME_BITS];

	// syndrome contribution of each packet bit; the check is linear, so the
	// whole check is the xor of the columns of the set bits (zero means pass)
	function automatic crc_col_t crc_cols();
		crc_col_t cols;
		logic [FRAME_BITS-1:0] d;
		logic [7:0] msg [4];
		logic [7:0] rem;
		for (int i = 0; i < FRAME_BITS; i++) begin
			d = FRAME_BITS'(1) << i;
			msg[0] = d[39:32];
			msg[1] = {d[3:0], d[27:24]};
			msg[2] = d[23:16];
			msg[3] = d[15:8];
			rem = '0;
			for (int j = 0; j < 4; j++) begin
				rem ^= msg[j];
				for (int b = 0; b < 8; b++) begin
					rem = rem[7] ? ((rem << 1) ^ CRC_POLY) : (rem << 1);
				end
			end
			cols[i] = rem[7:4] ^ d[7:4] ^ d[31:28];
		end
		return cols;
	endfunction

	localparam crc_col_t CRC_COL = crc_cols();

endpackage

>>> hw/rtl/ook_weather_sensor_pulse_decoder.sv
// ----------------------------------------------------------------------------
// ook_weather_sensor_pulse_decoder: pulse-distance frame decoder with crc-4
// turns a stream of (level, duration) pulses into checked sensor packets
// ----------------------------------------------------------------------------
// Each input beat is one radio pulse: its level and its length in microseconds.
// A four-phase frame machine counts preamble pairs (high and low of about twice
// the short unit), takes the sync prefix (short high, gap of about sixteen short
// units) once more than three pairs were seen, then decodes pulse-distance bits:
// a gap of one long unit is 0, two long units is 1. A low pulse of at least
// thirty short units closes the frame; if exactly 40 bits came in and the crc-4
// (x^4+x+1 over the rearranged message, last nibble folded in) passes, one
// output beat carries the packet and its fields. Temperature is raw (tenths of
// a degree Fahrenheit plus 900). One pulse is taken every clock unless the
// input side stalls: a pulse is held in the input register, the frame machine
// and crc syndrome tree update in a single pass, and a packet enters the output
// register when its closing pulse leaves the input register. The input side
// stalls only while a packet waits unaccepted and a pulse sits behind it.
// Timing registers (short_unit, long_unit, tolerance) are written through the
// cfg port with the decoder idle; short-unit compares scale the tolerance by
// the nominal's factor, the sync gap by half of it (8x) and long-unit gaps by
// twice it (2x, 4x); a tolerance of zero matches nothing.
module ook_weather_sensor_pulse_decoder #(
	parameter int DURATION_WIDTH = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pulse input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            level,
	input  logic [DURATION_WIDTH-1:0]       duration,
	// packet output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ookwx_pkg::FRAME_BITS-1:0] raw_packet,
	output logic [7:0]                      sensor_id,
	output logic                            battery_low,
	output logic [11:0]                     temp_raw,
	output logic [7:0]                      humidity,
	output logic [1:0]                      channel,
	// register writes
	input  logic                            cfg_write,
	input  logic [ookwx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ookwx_pkg::CFG_W-1:0]     cfg_data
);
	import ookwx_pkg::*;

	// compare width: covers the pulse length and thirty short units
	localparam int CW = DURATION_WIDTH + 2;

	// timing registers
	logic [SHORT_W-1:0] short_unit_q;
	logic [LONG_W-1:0]  long_unit_q;
	logic [TOL_W-1:0]   tolerance_q;

	// input register
	logic                      valid_s1;
	logic                      level_s1;
	logic [DURATION_WIDTH-1:0] dur_s1;

	// frame state
	phase_t                    phase_q, phase_d;
	logic [DURATION_WIDTH-1:0] high_len_q, high_len_d;
	logic [PAIRS_W-1:0]        pairs_q, pairs_d;
	logic [FRAME_BITS-1:0]     shift_q, shift_d;
	logic [TOTAL_W-1:0]        total_q, total_d;

	// output register
	logic                  out_valid_q;
	logic [FRAME_BITS-1:0] packet_q;

	logic advance;
	logic emit;
	logic [3:0] syndrome;

	// scaled nominal lengths and tolerances
	logic [CW-1:0] dur_x, high_x;
	logic [CW-1:0] s1x, s2x, s16x, s30x, l1x, l2x;
	logic [CW-1:0] t1x, t2x, t4x, t8x;

	// match flags
	logic dur_pre, high_pre, high_short, dur_sync, dur_zero, dur_one, dur_end;

	function automatic logic near(input logic [CW-1:0] x, input logic [CW-1:0] nom,
		input logic [CW-1:0] tol);
		logic [CW-1:0] diff;
		diff = (x > nom) ? (x - nom) : (nom - x);
		return diff < tol;
	endfunction

	// the pass runs when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_unit_q <= SHORT_UNIT_RST;
			long_unit_q  <= LONG_UNIT_RST;
			tolerance_q  <= TOLERANCE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SHORT_UNIT: short_unit_q <= cfg_data[SHORT_W-1:0];
				REG_LONG_UNIT:  long_unit_q  <= cfg_data[LONG_W-1:0];
				REG_TOLERANCE:  tolerance_q  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= level;
			dur_s1   <= duration;
		end
	end

	// nominal lengths by shifts only
	always_comb begin
		dur_x  = CW'(dur_s1);
		high_x = CW'(high_len_q);
		s1x    = CW'(short_unit_q);
		s2x    = s1x << 1;
		s16x   = s1x << 4;
		s30x   = (s1x << 5) - s2x;
		l1x    = CW'(long_unit_q);
		l2x    = l1x << 1;
		t1x    = CW'(tolerance_q);
		t2x    = t1x << 1;
		t4x    = t1x << 2;
		t8x    = t1x << 3;

		dur_pre    = near(dur_x, s2x, t2x);
		high_pre   = near(high_x, s2x, t2x);
		high_short = near(high_x, s1x, t1x);
		dur_sync   = near(dur_x, s16x, t8x);
		dur_zero   = near(dur_x, l1x, t2x);
		dur_one    = near(dur_x, l2x, t4x);
		dur_end    = dur_x >= s30x;
	end

	// crc syndrome: xor of the columns of the set bits
	always_comb begin
		syndrome = '0;
		for (int i = 0; i < FRAME_BITS; i++) begin
			syndrome ^= shift_q[i] ? CRC_COL[i] : 4'd0;
		end
	end

	// frame machine next state
	always_comb begin
		phase_d    = phase_q;
		high_len_d = high_len_q;
		pairs_d    = pairs_q;
		shift_d    = shift_q;
		total_d    = total_q;
		emit       = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (level_s1 && dur_pre) begin
					phase_d    = PH_PREAMBLE;
					high_len_d = dur_s1;
					pairs_d    = '0;
				end
			end
			PH_PREAMBLE: begin
				if (level_s1) begin
					high_len_d = dur_s1;
				end else if (high_pre && dur_pre) begin
					if (pairs_q != PAIRS_MAX) pairs_d = pairs_q + 1'b1;
				end else if (high_short && dur_sync) begin
					// sync too early: stay and keep counting
					if (pairs_q > PAIRS_NEEDED) begin
						phase_d = PH_WAIT_HIGH;
						shift_d = '0;
						total_d = '0;
					end
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WAIT_HIGH: begin
				if (level_s1) begin
					high_len_d = dur_s1;
					phase_d    = PH_WAIT_GAP;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_WAIT_GAP: begin
				if (level_s1) begin
					phase_d = PH_IDLE;
				end else if (dur_end) begin
					emit    = (total_q == TOTAL_FRAME) && (syndrome == 4'd0);
					shift_d = '0;
					total_d = '0;
					phase_d = PH_IDLE;
				end else if (high_short && (dur_zero || dur_one)) begin
					// a zero gap wins when both windows overlap
					shift_d = {shift_q[FRAME_BITS-2:0], !dur_zero};
					if (total_q != TOTAL_MAX) total_d = total_q + 1'b1;
					phase_d = PH_WAIT_HIGH;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			high_len_q <= '0;
			pairs_q    <= '0;
			shift_q    <= '0;
			total_q    <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			high_len_q <= high_len_d;
			pairs_q    <= pairs_d;
			shift_q    <= shift_d;
			total_q    <= total_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			packet_q <= shift_q;
		end
	end

	// field unpacking from the held packet
	assign out_valid   = out_valid_q;
	assign raw_packet  = packet_q;
	assign sensor_id   = packet_q[39:32];
	assign battery_low = packet_q[26];
	assign temp_raw    = packet_q[23:12];
	assign humidity    = ({4'd0, packet_q[11:8]} << 3) + ({4'd0, packet_q[11:8]} << 1)
		+ {4'd0, packet_q[7:4]};
	assign channel     = packet_q[1:0];

endmodule
